@@ hw/rtl/lrrs_pkg.sv @@
// Package for the ranged LCG random source: kind codes, generator constants
// and the command/status structs between controller and datapath.
// Depends on nothing.
package lrrs_pkg;

  localparam int unsigned StateW = 24;
  localparam int unsigned DrawW  = 16;
  localparam int unsigned NumW   = 17;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_SEED   = 3'd0;
  localparam kind_t KIND_RAW    = 3'd1;
  localparam kind_t KIND_SIGNED = 3'd2;
  localparam kind_t KIND_RANGED = 3'd3;
  localparam kind_t KIND_MIN2   = 3'd4;

  // Only the low 24 bits of the multiplier reach the kept state.
  localparam logic [StateW-1:0] LCG_MUL    = 24'hC64E6D;
  localparam logic [StateW-1:0] LCG_INC    = 24'd12345;
  localparam logic [DrawW-1:0]  RANGE_TOP  = 16'hFFFF;
  localparam logic [DrawW-1:0]  SIGNED_MAX = 16'h7FFF;

  typedef enum logic [1:0] {
    RES_RAW    = 2'd0,
    RES_SIGNED = 2'd1,
    RES_MOD    = 2'd2,
    RES_MIN    = 2'd3
  } res_src_t;

  typedef struct packed {
    logic     load_item;
    logic     seed;
    logic     step;
    logic     div_start;
    logic     div_ceil;
    logic     ceil_load;
    logic     keep_first;
    logic     res_load;
    res_src_t res_src;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  reject;
    logic  div_done;
  } sts_t;

endpackage

@@ hw/rtl/lrrs_if.sv @@
// Handshake channels of the ranged LCG random source: the item channel and
// the result channel, each with valid, ready and payload.
// Depends on nothing.
interface lrrs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [23:0] seed_value;
  logic [14:0] limit;

  modport source(output valid, output kind, output seed_value, output limit, input ready);
  modport sink(input valid, input kind, input seed_value, input limit, output ready);
endinterface

interface lrrs_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] number;

  modport source(output valid, output number, input ready);
  modport sink(input valid, input number, output ready);
endinterface

@@ hw/rtl/lcg_ranged_random_source.sv @@
// Top level of the ranged LCG random source: controller plus datapath.
// Depends on lrrs_pkg, lrrs_if, lrrs_ctrl and lrrs_datapath.
//
//   channel  | direction | handshake   | payload
//   in_ch    | sink      | valid/ready | kind, seed_value, limit
//   out_ch   | source    | valid/ready | number
//
// One word is worked on at a time: no new word is taken before the last is done.
// A ranged draw runs the shared remainder divider twice, for the rejection bound
// and the remainder; a rejected draw steps again; minimum-of-two takes a second draw.
// Reset is synchronous and clears the generator state to zero.
// A waiting result sits in the output register while the next word is taken.
module lcg_ranged_random_source (
  input  logic       clk,
  input  logic       rst_n,
  lrrs_in_if.sink    in_ch,
  lrrs_out_if.source out_ch
);

  lrrs_pkg::cmd_t cmd;
  lrrs_pkg::sts_t sts;

  lrrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  lrrs_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_kind       (in_ch.kind),
    .in_seed_value (in_ch.seed_value),
    .in_limit      (in_ch.limit),
    .out_number    (out_ch.number)
  );

endmodule

@@ hw/rtl/lrrs_divider.sv @@
// Restoring divider, one quotient bit per cycle, returning only the remainder.
// Depends on lrrs_pkg for the draw width.
module lrrs_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lrrs_pkg::DrawW-1:0]   dividend,
  input  logic [lrrs_pkg::DrawW-1:0]   divisor,
  output logic                         done,
  output logic [lrrs_pkg::DrawW-1:0]   remainder
);

  localparam int unsigned CntW = $clog2(lrrs_pkg::DrawW);

  logic                        busy_r;
  logic                        done_r;
  logic [CntW-1:0]             cnt_r;
  logic [lrrs_pkg::DrawW-1:0]  dq_r;
  logic [lrrs_pkg::DrawW-1:0]  dvs_r;
  logic [lrrs_pkg::DrawW-1:0]  rem_r;
  logic [lrrs_pkg::DrawW:0]    rem_sh;
  logic [lrrs_pkg::DrawW:0]    rem_sub;
  logic [lrrs_pkg::DrawW-1:0]  rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, dq_r[lrrs_pkg::DrawW-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    if (rem_sh >= {1'b0, dvs_r}) begin
      rem_nxt = rem_sub[lrrs_pkg::DrawW-1:0];
    end else begin
      rem_nxt = rem_sh[lrrs_pkg::DrawW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CntW'(1);
        if (cnt_r == CntW'(lrrs_pkg::DrawW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dq_r  <= {dq_r[lrrs_pkg::DrawW-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

@@ hw/rtl/lrrs_datapath.sv @@
// Datapath: generator state with its multiply-add step, item registers,
// rejection bound, result selection and the output register.
// Depends on lrrs_pkg and lrrs_divider.
module lrrs_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lrrs_pkg::cmd_t                   cmd,
  output lrrs_pkg::sts_t                   sts,
  input  logic [2:0]                       in_kind,
  input  logic [lrrs_pkg::StateW-1:0]      in_seed_value,
  input  logic [14:0]                      in_limit,
  output logic signed [lrrs_pkg::NumW-1:0] out_number
);

  logic [lrrs_pkg::StateW-1:0]      state_r;
  logic [lrrs_pkg::StateW-1:0]      state_nxt;
  lrrs_pkg::kind_t                  kind_r;
  logic [lrrs_pkg::StateW-1:0]      seed_r;
  logic [lrrs_pkg::DrawW-1:0]       span_r;
  logic [lrrs_pkg::DrawW-1:0]       ceil_r;
  logic [lrrs_pkg::DrawW-1:0]       first_r;
  logic signed [lrrs_pkg::NumW-1:0] result_r;
  logic signed [lrrs_pkg::NumW-1:0] result_nxt;
  logic signed [lrrs_pkg::NumW-1:0] number_r;
  logic [lrrs_pkg::DrawW-1:0]       draw;
  logic [lrrs_pkg::DrawW-1:0]       div_dividend;
  logic [lrrs_pkg::DrawW-1:0]       div_rem;
  logic                             div_done;

  assign draw      = state_r[lrrs_pkg::StateW-1:8];
  assign state_nxt = state_r * lrrs_pkg::LCG_MUL + lrrs_pkg::LCG_INC;

  assign div_dividend = cmd.div_ceil ? lrrs_pkg::RANGE_TOP : draw;

  lrrs_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (span_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    case (cmd.res_src)
      lrrs_pkg::RES_RAW: begin
        result_nxt = $signed({1'b0, draw});
      end
      lrrs_pkg::RES_SIGNED: begin
        if (draw > lrrs_pkg::SIGNED_MAX) begin
          result_nxt = $signed({1'b0, lrrs_pkg::SIGNED_MAX}) - $signed({1'b0, draw});
        end else begin
          result_nxt = $signed({1'b0, draw});
        end
      end
      lrrs_pkg::RES_MOD: begin
        result_nxt = $signed({1'b0, div_rem});
      end
      default: begin
        result_nxt = (first_r < div_rem) ? $signed({1'b0, first_r})
                                         : $signed({1'b0, div_rem});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (cmd.seed) begin
      state_r <= seed_r;
    end else if (cmd.step) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r <= in_kind;
      seed_r <= in_seed_value;
      span_r <= {1'b0, in_limit} + 16'd1;
    end
    if (cmd.ceil_load) begin
      ceil_r <= lrrs_pkg::RANGE_TOP - div_rem;
    end
    if (cmd.keep_first) begin
      first_r <= div_rem;
    end
    if (cmd.res_load) begin
      result_r <= result_nxt;
    end
    if (cmd.out_load) begin
      number_r <= result_r;
    end
  end

  assign sts.kind     = kind_r;
  assign sts.reject   = (draw >= ceil_r);
  assign sts.div_done = div_done;
  assign out_number   = number_r;

endmodule

@@ hw/rtl/lrrs_ctrl.sv @@
// Controller state machine: sequences decode, draws, rejection, divider runs
// and the output register handshake.
// Depends on lrrs_pkg.
module lrrs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output lrrs_pkg::cmd_t cmd,
  input  lrrs_pkg::sts_t sts
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_CEIL   = 7'b0000100,
    S_STEP   = 7'b0001000,
    S_CHECK  = 7'b0010000,
    S_MOD    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   second_r;
  logic   second_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    second_nxt    = second_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.res_src   = lrrs_pkg::RES_RAW;
    cmd.load_item = (state_r == S_IDLE) && in_valid;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.kind) inside
          lrrs_pkg::KIND_SEED: begin
            cmd.seed  = 1'b1;
            state_nxt = S_IDLE;
          end
          lrrs_pkg::KIND_RAW, lrrs_pkg::KIND_SIGNED: begin
            state_nxt = S_STEP;
          end
          lrrs_pkg::KIND_RANGED, lrrs_pkg::KIND_MIN2: begin
            cmd.div_start = 1'b1;
            cmd.div_ceil  = 1'b1;
            second_nxt    = 1'b0;
            state_nxt     = S_CEIL;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_CEIL: begin
        if (sts.div_done) begin
          cmd.ceil_load = 1'b1;
          state_nxt     = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.kind == lrrs_pkg::KIND_RAW) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = lrrs_pkg::RES_RAW;
          state_nxt    = S_OUT;
        end else if (sts.kind == lrrs_pkg::KIND_SIGNED) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = lrrs_pkg::RES_SIGNED;
          state_nxt    = S_OUT;
        end else if (sts.reject) begin
          state_nxt = S_STEP;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.div_done) begin
          if (sts.kind == lrrs_pkg::KIND_RANGED) begin
            cmd.res_load = 1'b1;
            cmd.res_src  = lrrs_pkg::RES_MOD;
            state_nxt    = S_OUT;
          end else if (!second_r) begin
            cmd.keep_first = 1'b1;
            second_nxt     = 1'b1;
            state_nxt      = S_STEP;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_src  = lrrs_pkg::RES_MIN;
            state_nxt    = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for lcg_ranged_random_source: directed and random words
// checked against an in-bench model of the generator and its ranged draws.
// Depends on lrrs_pkg, lrrs_if and the lcg_ranged_random_source RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam realtime CLK_PERIOD = 10ns;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned RANDOM_WORDS = 1200;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned STRETCH_WORDS = 150;
  localparam lrrs_pkg::kind_t KIND_SPARE_FIRST = 3'd5;
  localparam lrrs_pkg::kind_t KIND_SPARE_LAST = 3'd7;
  localparam logic [31:0] LCG_MULTIPLIER = 32'd1103515245;
  localparam logic [31:0] LCG_INCREMENT = 32'd12345;
  localparam logic [16:0] DRAW_TOP = 17'h0ffff;
  localparam logic [16:0] SIGNED_LIMIT = 17'h07fff;
  localparam logic [14:0] LIMIT_MAX = 15'h7fff;

  logic clk = 1'b0;
  logic rst_n;

  lrrs_in_if in_ch();
  lrrs_out_if out_ch();

  lcg_ranged_random_source i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  logic [23:0] gen_state;
  logic signed [16:0] expected_numbers[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit idling_on;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int pick_gap();
    if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [15:0] next_draw();
    logic [31:0] product;
    product = {8'd0, gen_state} * LCG_MULTIPLIER + LCG_INCREMENT;
    gen_state = product[23:0];
    return gen_state[23:8];
  endfunction

  function automatic logic [15:0] ranged_draw(logic [14:0] lim);
    logic [16:0] span;
    logic [16:0] ceiling;
    logic [15:0] v;
    span = {2'b00, lim} + 17'd1;
    ceiling = (DRAW_TOP / span) * span;
    do begin
      v = next_draw();
    end while ({1'b0, v} >= ceiling);
    return 16'({1'b0, v} % span);
  endfunction

  function automatic logic [14:0] random_limit();
    case ($urandom_range(0, 9)) inside
      [0:3]: return 15'($urandom_range(0, 15));
      [4:6]: return 15'($urandom_range(0, 32767));
      7: return LIMIT_MAX;
      default: return 15'((1 << $urandom_range(0, 15)) - 1);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_word(input lrrs_pkg::kind_t word_kind, input logic [23:0] seed,
                           input logic [14:0] lim);
    int gap;
    logic [15:0] v;
    logic [15:0] first;
    logic [15:0] second;
    gap = (idling_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= word_kind;
    in_ch.seed_value <= seed;
    in_ch.limit <= lim;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    case (word_kind)
      lrrs_pkg::KIND_SEED: gen_state = seed;
      lrrs_pkg::KIND_RAW: expected_numbers.push_back({1'b0, next_draw()});
      lrrs_pkg::KIND_SIGNED: begin
        v = next_draw();
        if ({1'b0, v} > SIGNED_LIMIT) begin
          expected_numbers.push_back(17'(SIGNED_LIMIT - {1'b0, v}));
        end else begin
          expected_numbers.push_back({1'b0, v});
        end
      end
      lrrs_pkg::KIND_RANGED: expected_numbers.push_back({1'b0, ranged_draw(lim)});
      lrrs_pkg::KIND_MIN2: begin
        first = ranged_draw(lim);
        second = ranged_draw(lim);
        expected_numbers.push_back({1'b0, (first < second) ? first : second});
      end
      default: ;
    endcase
  endtask

  task automatic random_word();
    int roll;
    lrrs_pkg::kind_t word_kind;
    roll = $urandom_range(0, 99);
    if (roll < 6) word_kind = lrrs_pkg::KIND_SEED;
    else if (roll < 9) begin
      word_kind = lrrs_pkg::kind_t'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    end
    else if (roll < 30) word_kind = lrrs_pkg::KIND_RAW;
    else if (roll < 50) word_kind = lrrs_pkg::KIND_SIGNED;
    else if (roll < 78) word_kind = lrrs_pkg::KIND_RANGED;
    else word_kind = lrrs_pkg::KIND_MIN2;
    send_word(word_kind, 24'($urandom()), random_limit());
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_numbers.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_draws();
    send_word(lrrs_pkg::KIND_RAW, '0, '0);
    send_word(lrrs_pkg::KIND_SIGNED, '0, '0);
  endtask

  task automatic test_seed_extremes();
    send_word(lrrs_pkg::KIND_SEED, 24'h000000, LIMIT_MAX);
    send_word(lrrs_pkg::KIND_RAW, '0, '0);
    send_word(lrrs_pkg::KIND_SEED, 24'hffffff, '0);
    send_word(lrrs_pkg::KIND_RAW, '0, '0);
    send_word(lrrs_pkg::KIND_SEED, 24'haaaaaa, 15'h2aaa);
    send_word(lrrs_pkg::KIND_SIGNED, '0, '0);
    send_word(lrrs_pkg::KIND_SEED, 24'h555555, 15'h5555);
    send_word(lrrs_pkg::KIND_SIGNED, '0, '0);
    send_word(lrrs_pkg::KIND_SIGNED, '0, '0);
  endtask

  task automatic test_ranged_extremes();
    send_word(lrrs_pkg::KIND_RANGED, '0, 15'd0);
    send_word(lrrs_pkg::KIND_RANGED, '0, LIMIT_MAX);
    send_word(lrrs_pkg::KIND_RANGED, '0, 15'd1);
    send_word(lrrs_pkg::KIND_RANGED, '0, 15'd21845);
    send_word(lrrs_pkg::KIND_MIN2, '0, 15'd0);
    send_word(lrrs_pkg::KIND_MIN2, '0, LIMIT_MAX);
    send_word(lrrs_pkg::KIND_MIN2, '0, 15'd9);
  endtask

  task automatic test_spare_kinds();
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
      send_word(lrrs_pkg::kind_t'(k), 24'($urandom()), 15'($urandom()));
    end
    send_word(lrrs_pkg::KIND_RAW, '0, '0);
  endtask

  task automatic test_drain_pause();
    repeat (20) random_word();
    wait_for_drain();
    repeat (20) random_word();
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      idling_on = ((i / STRETCH_WORDS) % 3) != 2;
      random_word();
    end
    idling_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= pick_gap() - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic signed [16:0] expected;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_numbers.size() == 0) begin
        report_mismatch($sformatf("unexpected result number %0d", out_ch.number));
      end else begin
        expected = expected_numbers.pop_front();
        if (out_ch.number !== expected) begin
          report_mismatch($sformatf("number got %0d expected %0d", out_ch.number, expected));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    do begin
      @(posedge clk);
    end while (idle_cycles < WATCHDOG_LIMIT);
    $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= lrrs_pkg::KIND_SEED;
    in_ch.seed_value <= '0;
    in_ch.limit <= '0;
    idling_on = 1'b1;
    gen_state = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_draws();
    test_seed_extremes();
    test_ranged_extremes();
    test_spare_kinds();
    test_drain_pause();
    test_random_mix();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
